// File: hdl/cle_pkg.sv
package cle_pkg;

	localparam int POOL_DEPTH = 64;
	localparam int VAL_W      = 32;
	localparam int IDX_W      = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int KIND_W     = 4;
	localparam int POS_W      = 7;
	localparam int STAT_W     = 3;

	localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 4'd5;
	localparam logic [KIND_W-1:0] KIND_UPD_FIRST = 4'd10;
	localparam logic [KIND_W-1:0] KIND_SEARCH    = 4'd15;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_BAD_POS   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {C_INS, C_DEL, C_UPD, C_SRCH} cls_t;

	typedef enum logic [2:0] {
		OP_END, OP_BEGIN, OP_BEFORE, OP_AFTER, OP_POS
	} op_t;

	typedef struct packed {
		logic        [KIND_W-1:0] kind;
		logic signed [VAL_W-1:0]  new_value;
		logic signed [VAL_W-1:0]  key;
		logic        [POS_W-1:0]  position;
	} req_word_t;

	typedef struct packed {
		logic        [STAT_W-1:0] status;
		logic signed [VAL_W-1:0]  removed_value;
		logic        [POS_W-1:0]  found_position;
		logic        [POS_W-1:0]  entries;
	} rsp_word_t;

	function automatic cls_t cls_of(input logic [KIND_W-1:0] kind);
		if (kind == KIND_SEARCH)        return C_SRCH;
		else if (kind >= KIND_UPD_FIRST) return C_UPD;
		else if (kind >= KIND_DEL_FIRST) return C_DEL;
		else                            return C_INS;
	endfunction

	function automatic op_t op_of(input logic [KIND_W-1:0] kind);
		logic [KIND_W-1:0] r;
		if (kind == KIND_SEARCH)         r = '0;
		else if (kind >= KIND_UPD_FIRST) r = kind - KIND_UPD_FIRST;
		else if (kind >= KIND_DEL_FIRST) r = kind - KIND_DEL_FIRST;
		else                             r = kind;
		case (r[2:0])
			3'd0:    return OP_END;
			3'd1:    return OP_BEGIN;
			3'd2:    return OP_BEFORE;
			3'd3:    return OP_AFTER;
			default: return OP_POS;
		endcase
	endfunction

endpackage

// File: hdl/cle_req_if.sv
interface cle_req_if;
	import cle_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/cle_rsp_if.sv
interface cle_rsp_if;
	import cle_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/circular_list_engine.sv
// channel | dir | handshake     | word
// req     | in  | valid/ready   | kind, new_value, key, position
// rsp     | out | valid/ready   | status, removed_value, found_position, entries
//
// One request at a time. After acceptance the walk visits the nodes from the head (up to
// the list length, one link read per cycle from the link memories), then come the fetch
// and write states (none for search, S_UPD for update, S_INS1 and S_INS2 for insert,
// S_FETCH and S_DEL for delete), then S_DONE loads the response register. A request
// refused at decode (empty list, bad position) goes from acceptance straight to S_DONE.
// Reset clears head, count and the free-stack watermark; no clearing pass is needed.
// A response waiting in the output register does not block acceptance; only
// the loading of the next response waits for it to be taken.
module circular_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	cle_req_if.sink    req,
	cle_rsp_if.source  rsp
);
	import cle_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_WALK, S_FETCH, S_DEL, S_UPD, S_INS1, S_INS2, S_DONE
	} state_t;

	typedef enum logic [1:0] {W_FIRST, W_POS, W_KEY} walk_t;

	// storage: one write and one registered read per memory per cycle
	logic [VAL_W-1:0] val_mem  [POOL_DEPTH];
	logic [IDX_W-1:0] nxt_mem  [POOL_DEPTH];
	logic [IDX_W-1:0] prv_mem  [POOL_DEPTH];
	logic [IDX_W-1:0] free_mem [POOL_DEPTH];

	logic [VAL_W-1:0] val_rd;
	logic [IDX_W-1:0] nxt_rd, prv_rd, fr_rd;

	state_t           state_q;
	walk_t            mode_q;
	cls_t             cls_q;
	op_t              op_q;
	logic             empty_q, append_q;
	logic [IDX_W-1:0] head_q, cur_q, tgt_q, tprev_q, tnext_q;
	logic [CNT_W-1:0] count_q, hwm_q, walk_pos_q;
	logic [POS_W-1:0] goal_q;
	logic [VAL_W-1:0] key_q, nv_q;
	status_t          res_status_q;
	logic [VAL_W-1:0] res_removed_q;
	logic [POS_W-1:0] res_found_q;
	logic             out_valid_q;
	rsp_word_t        out_q;

	// request decode
	cls_t             in_cls;
	op_t              in_op;
	logic [CNT_W:0]   pos_lim;
	logic             accept;

	// datapath selects
	logic [IDX_W-1:0] rd_addr, new_node, t_addr, link_s, link_p;
	logic             hit, miss;

	logic             val_we, nxt_we, prv_we, free_we;
	logic [IDX_W-1:0] val_wa, nxt_wa, prv_wa;
	logic [IDX_W-1:0] nxt_wd, prv_wd;
	logic [VAL_W-1:0] val_wd;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_cls    = cls_of(req.data.kind);
	assign in_op     = op_of(req.data.kind);
	assign pos_lim   = {1'b0, count_q} + ((in_cls == C_INS) ? 1'b1 : 1'b0);

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// take the fresh index at the watermark once the count reaches it, else pop the free stack
	assign new_node = (count_q >= hwm_q) ? count_q[IDX_W-1:0] : fr_rd;

	// node acted on by delete and update
	always_comb begin
		case (op_q)
			OP_END, OP_BEFORE: t_addr = tprev_q;
			OP_AFTER:          t_addr = tnext_q;
			default:           t_addr = tgt_q;
		endcase
	end

	// insert n between link_p and link_s
	always_comb begin
		if (empty_q) begin
			link_s = new_node;
			link_p = new_node;
		end else if (op_q == OP_END || op_q == OP_BEGIN || append_q) begin
			link_s = head_q;
			link_p = tprev_q;
		end else if (op_q == OP_AFTER) begin
			link_s = tnext_q;
			link_p = tgt_q;
		end else begin
			link_s = tgt_q;
			link_p = tprev_q;
		end
	end

	always_comb begin
		case (state_q)
			S_WALK:  rd_addr = nxt_rd;
			S_FETCH: rd_addr = t_addr;
			default: rd_addr = head_q;
		endcase
	end

	assign hit  = (mode_q == W_FIRST)
		|| (mode_q == W_POS && POS_W'(walk_pos_q) == goal_q)
		|| (mode_q == W_KEY && val_rd == key_q);
	assign miss = !hit && walk_pos_q == count_q;

	// write ports
	always_comb begin
		val_we  = 1'b0;
		val_wa  = new_node;
		val_wd  = nv_q;
		nxt_we  = 1'b0;
		nxt_wa  = new_node;
		nxt_wd  = link_s;
		prv_we  = 1'b0;
		prv_wa  = new_node;
		prv_wd  = link_p;
		free_we = 1'b0;
		case (state_q)
			S_INS1: begin
				val_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			S_INS2: begin
				nxt_we = 1'b1;
				nxt_wa = link_p;
				nxt_wd = new_node;
				prv_we = 1'b1;
				prv_wa = link_s;
				prv_wd = new_node;
			end
			S_DEL: begin
				nxt_we  = 1'b1;
				nxt_wa  = prv_rd;
				nxt_wd  = nxt_rd;
				prv_we  = 1'b1;
				prv_wa  = nxt_rd;
				prv_wd  = prv_rd;
				free_we = 1'b1;
			end
			S_UPD: begin
				val_we = 1'b1;
				val_wa = t_addr;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_wa] <= val_wd;
		val_rd <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		nxt_rd <= nxt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		prv_rd <= prv_mem[rd_addr];
	end

	// freed node goes to the slot of the new count
	always_ff @(posedge clk) begin
		if (free_we) free_mem[IDX_W'(count_q - 1'b1)] <= t_addr;
		fr_rd <= free_mem[count_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			hwm_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the taken word; the done state reloads it itself
			if (out_valid_q && rsp.ready && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cls_q         <= in_cls;
						op_q          <= in_op;
						key_q         <= req.data.key;
						nv_q          <= req.data.new_value;
						cur_q         <= head_q;
						walk_pos_q    <= CNT_W'(1);
						goal_q        <= req.data.position;
						empty_q       <= 1'b0;
						append_q      <= 1'b0;
						res_status_q  <= ST_OK;
						res_removed_q <= '0;
						res_found_q   <= '0;
						state_q       <= S_WALK;
						if (count_q == '0 && !(in_cls == C_INS
								&& (in_op == OP_END || in_op == OP_BEGIN))) begin
							// empty list: only end and begin inserts proceed
							res_status_q <= ST_EMPTY;
							state_q      <= S_DONE;
						end else if (count_q == '0 && in_cls == C_INS) begin
							empty_q <= 1'b1;
							mode_q  <= W_FIRST;
						end else if (in_cls == C_SRCH || in_op == OP_BEFORE
								|| in_op == OP_AFTER) begin
							mode_q <= W_KEY;
						end else if (in_op == OP_POS) begin
							mode_q <= W_POS;
							if (req.data.position == '0
									|| (CNT_W+1)'(req.data.position) > pos_lim) begin
								res_status_q <= ST_BAD_POS;
								state_q      <= S_DONE;
							end else if (in_cls == C_INS
									&& (CNT_W+1)'(req.data.position) == pos_lim) begin
								// one past the tail: append
								append_q <= 1'b1;
								goal_q   <= POS_W'(1);
							end
						end else begin
							mode_q <= W_FIRST;
						end
					end
				end
				S_WALK: begin
					if (hit) begin
						tgt_q   <= cur_q;
						tprev_q <= prv_rd;
						tnext_q <= nxt_rd;
						case (cls_q)
							C_SRCH: begin
								res_found_q <= POS_W'(walk_pos_q);
								state_q     <= S_DONE;
							end
							C_INS: begin
								if (count_q == CNT_W'(POOL_DEPTH)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_INS1;
								end
							end
							C_DEL:   state_q <= S_FETCH;
							default: state_q <= S_UPD;
						endcase
					end else if (miss) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						// advance one link
						cur_q      <= nxt_rd;
						walk_pos_q <= walk_pos_q + 1'b1;
					end
				end
				S_FETCH: state_q <= S_DEL;
				S_DEL: begin
					res_removed_q <= val_rd;
					count_q       <= count_q - 1'b1;
					if (count_q == CNT_W'(1)) head_q <= '0;
					else if (t_addr == head_q) head_q <= nxt_rd;
					state_q <= S_DONE;
				end
				S_UPD:  state_q <= S_DONE;
				S_INS1: state_q <= S_INS2;
				S_INS2: begin
					count_q <= count_q + 1'b1;
					if (count_q >= hwm_q) hwm_q <= count_q + 1'b1;
					if (empty_q || op_q == OP_BEGIN) begin
						head_q <= new_node;
					end else if ((op_q == OP_BEFORE || op_q == OP_POS) && !append_q
							&& tgt_q == head_q) begin
						head_q <= new_node;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q          <= 1'b1;
						out_q.status         <= res_status_q;
						out_q.removed_value  <= res_removed_q;
						out_q.found_position <= res_found_q;
						out_q.entries        <= POS_W'(count_q);
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(POOL_DEPTH))
		else $error("entry count beyond pool");

	a_watermark: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hwm_q)
		else $error("free-stack watermark below entry count");

	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEL |=> count_q == CNT_W'($past(count_q) - 1'b1))
		else $error("delete did not drop the count by one");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && count_q == '0) |-> head_q == '0)
		else $error("empty list with non-zero head");

endmodule

// File: verif/tb_circular_list_engine.sv
module tb_circular_list_engine;
	import cle_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_WORDS   = 1590;

	logic clk;
	logic arst_n;

	cle_req_if req ();
	cle_rsp_if rsp ();

	circular_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// predictor state: a plain ordered array stands in for the linked pool
	logic signed [VAL_W-1:0] list_vals[$];

	req_word_t pending_words[$];
	rsp_word_t expected_rsps[$];

	int  errors;
	int  checked;
	int  idle_pct;
	int  ready_pct;
	int  hold_off;
	int  quiet_cycles;
	int  seen_status[5];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// work out the response a request should give and update the list copy
	function automatic rsp_word_t apply_request(req_word_t w);
		rsp_word_t r;
		int        cnt;
		int        hit;
		int        idx;
		int        p;
		cls_t      c;
		op_t       o;
		r   = '0;
		cnt = list_vals.size();
		c   = cls_of(w.kind);
		o   = op_of(w.kind);
		p   = w.position;
		hit = -1;
		foreach (list_vals[i])
			if (hit < 0 && list_vals[i] == w.key) hit = i;
		if (cnt == 0 && !(c == C_INS && (o == OP_END || o == OP_BEGIN))) begin
			r.status = ST_EMPTY;
		end else if (c == C_SRCH) begin
			if (hit < 0) r.status = ST_NOT_FOUND;
			else r.found_position = POS_W'(hit + 1);
		end else if ((o == OP_BEFORE || o == OP_AFTER) && hit < 0) begin
			r.status = ST_NOT_FOUND;
		end else if (o == OP_POS && (p == 0 || p > cnt + (c == C_INS ? 1 : 0))) begin
			r.status = ST_BAD_POS;
		end else if (c == C_INS) begin
			if (cnt >= POOL_DEPTH) r.status = ST_FULL;
			else begin
				case (o)
					OP_END:    idx = cnt;
					OP_BEGIN:  idx = 0;
					OP_BEFORE: idx = hit;
					OP_AFTER:  idx = hit + 1;
					default:   idx = p - 1;
				endcase
				list_vals.insert(idx, w.new_value);
			end
		end else begin
			// neighbours wrap round the ends
			case (o)
				OP_END:    idx = cnt - 1;
				OP_BEGIN:  idx = 0;
				OP_BEFORE: idx = (hit + cnt - 1) % cnt;
				OP_AFTER:  idx = (hit + 1) % cnt;
				default:   idx = p - 1;
			endcase
			if (c == C_DEL) begin
				r.removed_value = list_vals[idx];
				list_vals.delete(idx);
			end else begin
				list_vals[idx] = w.new_value;
			end
		end
		r.entries = POS_W'(list_vals.size());
		return r;
	endfunction

	function automatic req_word_t make_word(int kind, int nv, int key, int pos);
		req_word_t w;
		w.kind      = KIND_W'(kind);
		w.new_value = nv;
		w.key       = key;
		w.position  = POS_W'(pos);
		return w;
	endfunction

	// pick keys mostly from a small pool so matches are common
	function automatic int pick_value();
		case ($urandom_range(0, 9))
			0:       return $urandom();
			1:       return 32'h8000_0000;
			2:       return 32'h7fff_ffff;
			default: return $urandom_range(0, 11) - 4;
		endcase
	endfunction

	task automatic queue_word(req_word_t w);
		pending_words.push_back(w);
	endtask

	// driver: advance the pending queue with random gaps, hold an offered word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data  <= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_rsps.push_back(apply_request(req.data));
				void'(pending_words.pop_front());
			end
			if (req.valid && !req.ready) begin
				// hold the waiting word
			end else if (pending_words.size() > (req.valid && req.ready ? 1 : 0)
			    && $urandom_range(0, 99) >= idle_pct) begin
				req.valid <= 1'b1;
				req.data  <= pending_words[(req.valid && req.ready) ? 1 : 0];
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// monitor: check each word taken from the response channel
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t exp_w;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (expected_rsps.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected response %p", rsp.data);
				end else begin
					exp_w = expected_rsps.pop_front();
					if (exp_w.status <= 4) seen_status[exp_w.status]++;
					if (rsp.data !== exp_w) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p got %p", exp_w, rsp.data);
					end
				end
			end
			if (hold_off > 0) begin
				hold_off  <= hold_off - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= $urandom_range(0, 99) >= ready_pct;
			end
		end
	end

	// watchdog: count cycles with no accepted word on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else if (arst_n) quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d responses outstanding", expected_rsps.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_words.size() != 0 || req.valid || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int k;
		errors       = 0;
		checked      = 0;
		quiet_cycles = 0;
		hold_off     = 0;
		idle_pct     = 13;
		ready_pct    = 13;
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.data     = '0;
		rsp.ready    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every kind in turn, starting on an empty list, then extremes and wrap cases
		for (k = 0; k < 16; k++) queue_word(make_word(k, 32'h7fff_ffff, 0, 1));
		queue_word(make_word(1, 32'h8000_0000, 0, 0));
		queue_word(make_word(6, 0, 0, 0));
		queue_word(make_word(0, 5, 0, 0));
		queue_word(make_word(7, 0, 5, 0));       // delete before the only node
		queue_word(make_word(4, -1, 0, 127));    // out-of-range position on an empty list: refused as empty
		queue_word(make_word(0, -1, 0, 0));
		queue_word(make_word(4, 9, 0, 3));
		queue_word(make_word(13, 7, 9, 0));      // update after a key that is not in the list
		queue_word(make_word(9, 0, 0, 127));
		queue_word(make_word(15, 0, 42, 0));
		queue_word(make_word(14, 1, 0, 0));
		wait_drained();

		// fill the pool to the brim while the receiver holds off
		hold_off = 300;
		for (k = 0; k < POOL_DEPTH + 2; k++) queue_word(make_word(k % 2, k, 0, 0));
		queue_word(make_word(4, 1, 0, 65));
		queue_word(make_word(2, 1, 3, 0));
		queue_word(make_word(15, 0, 63, 0));
		queue_word(make_word(9, 0, 0, 64));
		wait_drained();
		for (k = 0; k < POOL_DEPTH + 1; k++) queue_word(make_word(5 + k % 2, 0, 0, 0));
		wait_drained();

		// random traffic over all kinds; one stretch with no idle gaps and the receiver always ready
		for (k = 0; k < RANDOM_WORDS; k++) begin
			if (k == 700) begin
				wait_drained();
				idle_pct  = 0;
				ready_pct = 0;
			end
			if (k == 1000) begin
				idle_pct  = 13;
				ready_pct = 13;
			end
			if ($urandom_range(0, 2) == 0)
				queue_word(make_word($urandom_range(0, 15), pick_value(), pick_value(),
				                     $urandom_range(0, 127)));
			else
				queue_word(make_word($urandom_range(0, 15), pick_value(), pick_value(),
				                     $urandom_range(0, 20)));
			while (pending_words.size() > 8) @(posedge clk);
		end
		wait_drained();
		repeat (100) @(posedge clk);

		$display("checked %0d responses: ok %0d, empty %0d, not found %0d, bad pos %0d, full %0d",
		         checked, seen_status[0], seen_status[1], seen_status[2], seen_status[3],
		         seen_status[4]);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d responses missing", errors, expected_rsps.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/cle_pkg.sv
hdl/cle_req_if.sv
hdl/cle_rsp_if.sv
hdl/circular_list_engine.sv
verif/tb_circular_list_engine.sv
